>>> rtl/tcgr_pkg.sv
// Shared types and constants for the text console glyph renderer.
package tcgr_pkg;

  localparam int AddrW   = 48;
  localparam int PixW    = 16;
  localparam int ColorW  = 32;
  localparam int CurW    = 10;
  localparam int CountW  = 11;
  localparam int GwW     = 5;
  localparam int GhW     = 6;
  localparam int PitchW  = 16;
  localparam int MulW    = 16;
  localparam int ApbAw   = 6;
  localparam int ApbDw   = 64;
  localparam int RowCapAbs = 32;

  localparam logic [7:0] ChBackspace = 8'h08;
  localparam logic [7:0] ChNewline   = 8'h0A;
  localparam logic [7:0] ChPrintLo   = 8'h20;
  localparam logic [7:0] ChPrintEnd  = 8'h7F;

  localparam logic [CountW-1:0] CursorLimit = 11'd1024;

  localparam logic [AddrW-1:0]  FrameBaseRst  = '0;
  localparam logic [PitchW-1:0] LinePitchRst  = 16'd4096;
  localparam logic [GwW-1:0]    GlyphWidthRst = 5'd8;
  localparam logic [GhW-1:0]    GlyphHeightRst = 6'd16;
  localparam logic [CountW-1:0] TextColsRst   = 11'd80;
  localparam logic [CountW-1:0] TextRowsRst   = 11'd25;
  localparam logic [ColorW-1:0] TextColorRst  = 32'h0000ff;

  typedef enum logic [2:0] {
    REG_FRAME_BASE   = 3'd0,
    REG_LINE_PITCH   = 3'd1,
    REG_GLYPH_WIDTH  = 3'd2,
    REG_GLYPH_HEIGHT = 3'd3,
    REG_TEXT_COLUMNS = 3'd4,
    REG_TEXT_ROWS    = 3'd5,
    REG_TEXT_COLOR   = 3'd6
  } reg_idx_e;

  typedef struct packed {
    logic [AddrW-1:0]  frame_base;
    logic [PitchW-1:0] line_pitch;
    logic [GwW-1:0]    glyph_width;
    logic [GhW-1:0]    glyph_height;
    logic [CountW-1:0] text_columns;
    logic [CountW-1:0] text_rows;
    logic [ColorW-1:0] text_color;
  } cfg_t;

endpackage

>>> rtl/tcgr_if.sv
// Request and result channel interfaces of the glyph renderer.
interface tcgr_req_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [7:0]  char_code;
  logic [4:0]  glyph_line;
  logic [15:0] line_bits;

  modport source (output valid, op, char_code, glyph_line, line_bits, input ready);
  modport sink   (input valid, op, char_code, glyph_line, line_bits, output ready);
endinterface

interface tcgr_rsp_if;
  logic        valid;
  logic        ready;
  logic [47:0] write_address;
  logic [15:0] pixel_mask;
  logic [31:0] pixel_color;
  logic        last_row;

  modport source (output valid, write_address, pixel_mask, pixel_color, last_row,
                  input ready);
  modport sink   (input valid, write_address, pixel_mask, pixel_color, last_row,
                  output ready);
endinterface

>>> rtl/tcgr_ram.sv
// Generic simple dual-port RAM with registered read.
module tcgr_ram #(
  parameter int Width = 16,
  parameter int Depth = 8192
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/tcgr_mul.sv
// Shared 16x16 multiplier with registered product.
module tcgr_mul
  import tcgr_pkg::*;
(
  input  logic                clk_i,
  input  logic                en_i,
  input  logic [MulW-1:0]     a_i,
  input  logic [MulW-1:0]     b_i,
  output logic [2*MulW-1:0]   prod_o
);

  logic [2*MulW-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= a_i * b_i;
    end
  end

  assign prod_o = prod_q;

endmodule

>>> rtl/tcgr_cfg.sv
// APB configuration register file.
module tcgr_cfg
  import tcgr_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [ApbAw-1:0] paddr,
  input  logic [ApbDw-1:0] pwdata,
  output logic [ApbDw-1:0] prdata,
  output logic             pready,
  output cfg_t             cfg_o
);

  cfg_t     cfg_q;
  logic     wr;
  reg_idx_e idx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = reg_idx_e'(paddr[ApbAw-1:3]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.frame_base   <= FrameBaseRst;
      cfg_q.line_pitch   <= LinePitchRst;
      cfg_q.glyph_width  <= GlyphWidthRst;
      cfg_q.glyph_height <= GlyphHeightRst;
      cfg_q.text_columns <= TextColsRst;
      cfg_q.text_rows    <= TextRowsRst;
      cfg_q.text_color   <= TextColorRst;
    end else if (wr) begin
      unique case (idx)
        REG_FRAME_BASE:   cfg_q.frame_base   <= pwdata[AddrW-1:0];
        REG_LINE_PITCH:   cfg_q.line_pitch   <= pwdata[PitchW-1:0];
        REG_GLYPH_WIDTH:  cfg_q.glyph_width  <= pwdata[GwW-1:0];
        REG_GLYPH_HEIGHT: cfg_q.glyph_height <= pwdata[GhW-1:0];
        REG_TEXT_COLUMNS: cfg_q.text_columns <= pwdata[CountW-1:0];
        REG_TEXT_ROWS:    cfg_q.text_rows    <= pwdata[CountW-1:0];
        REG_TEXT_COLOR:   cfg_q.text_color   <= pwdata[ColorW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      REG_FRAME_BASE:   prdata = ApbDw'(cfg_q.frame_base);
      REG_LINE_PITCH:   prdata = ApbDw'(cfg_q.line_pitch);
      REG_GLYPH_WIDTH:  prdata = ApbDw'(cfg_q.glyph_width);
      REG_GLYPH_HEIGHT: prdata = ApbDw'(cfg_q.glyph_height);
      REG_TEXT_COLUMNS: prdata = ApbDw'(cfg_q.text_columns);
      REG_TEXT_ROWS:    prdata = ApbDw'(cfg_q.text_rows);
      REG_TEXT_COLOR:   prdata = ApbDw'(cfg_q.text_color);
      default:          prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

>>> rtl/text_console_glyph_renderer_core.sv
// Text console glyph renderer top level: cursor, sequencer and row emission.
//
//   channel  dir  handshake              payload
//   req_i    in   valid/ready            op, char_code, glyph_line, line_bits
//   rsp_o    out  valid/ready            write_address, pixel_mask, pixel_color, last_row
//   apb      in   psel/penable, pready=1 paddr, pwdata, prdata
//
// Load and control requests are taken in the idle state. A printable character runs
// address set-up on the shared multiplier and adder (row, pitch, column, column add),
// one glyph row a cycle from the glyph RAM while results are taken, one cursor update.
// Result stalls hold row emission; the result register lets the next request in.
// Reset clears cursor and sequencer; the glyph RAM holds nothing until loaded.
module text_console_glyph_renderer_core
  import tcgr_pkg::*;
#(
  parameter int GLYPH_COUNT    = 256,
  parameter int MAX_GLYPH_ROWS = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  tcgr_req_if.sink         req_i,
  tcgr_rsp_if.source       rsp_o,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [ApbAw-1:0] paddr,
  input  logic [ApbDw-1:0] pwdata,
  output logic [ApbDw-1:0] prdata,
  output logic             pready
);

  localparam int Depth  = GLYPH_COUNT * MAX_GLYPH_ROWS;
  localparam int RamAw  = $clog2(Depth);
  localparam int RowCap = (MAX_GLYPH_ROWS < RowCapAbs) ? MAX_GLYPH_ROWS : RowCapAbs;

  typedef enum logic [2:0] {
    S_IDLE, S_MROW, S_MPITCH, S_MCOL, S_ADDCOL, S_EMIT, S_ADV
  } state_e;

  state_e            state_q;
  cfg_t              cfg;
  logic [CurW-1:0]   row_q, col_q;
  logic [7:0]        code_q;
  logic [GhW-1:0]    y_q;
  logic [AddrW-1:0]  acc_q;
  logic              rsp_valid_q;
  logic [AddrW-1:0]  rsp_addr_q;
  logic [PixW-1:0]   rsp_mask_q;
  logic [ColorW-1:0] rsp_color_q;
  logic              rsp_last_q;

  logic [GhW-1:0]    h_eff;
  logic [GwW-1:0]    w_eff;
  logic [PixW-1:0]   keep;
  logic              accept, printable, base_on, out_free, last;
  logic [CountW-1:0] col_limit, row_limit;
  logic              col_wrap, row_wrap;
  logic              mul_en;
  logic [MulW-1:0]   mul_a, mul_b;
  logic [2*MulW-1:0] prod;
  logic              ram_we, ram_re;
  logic [RamAw-1:0]  ram_waddr, ram_raddr;
  logic [PixW-1:0]   ram_rdata;
  logic [GhW-1:0]    rd_line;

  tcgr_cfg u_cfg (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .cfg_o (cfg)
  );

  assign h_eff = (cfg.glyph_height > GhW'(RowCap)) ? GhW'(RowCap) : cfg.glyph_height;
  assign w_eff = (cfg.glyph_width > GwW'(PixW)) ? GwW'(PixW) : cfg.glyph_width;
  assign keep  = ~(16'hFFFF >> w_eff);

  assign accept    = req_i.valid && req_i.ready;
  assign printable = (req_i.char_code >= ChPrintLo) && (req_i.char_code < ChPrintEnd);
  assign base_on   = (cfg.frame_base != '0);
  assign out_free  = !rsp_valid_q || rsp_o.ready;
  assign last      = ((y_q + GhW'(1)) == h_eff);

  assign col_limit = (cfg.text_columns > CursorLimit) ? CursorLimit : cfg.text_columns;
  assign row_limit = (cfg.text_rows > CursorLimit) ? CursorLimit : cfg.text_rows;
  assign col_wrap  = ((CountW'(col_q) + CountW'(1)) >= col_limit);
  assign row_wrap  = ((CountW'(row_q) + CountW'(1)) >= row_limit);

  // shared multiplier operand select
  always_comb begin
    mul_en = 1'b0;
    mul_a  = '0;
    mul_b  = '0;
    unique case (state_q)
      S_MROW: begin
        mul_en = 1'b1;
        mul_a  = MulW'(row_q);
        mul_b  = MulW'(h_eff) + MulW'(1);
      end
      S_MPITCH: begin
        mul_en = 1'b1;
        mul_a  = prod[MulW-1:0];
        mul_b  = cfg.line_pitch;
      end
      S_MCOL: begin
        mul_en = 1'b1;
        mul_a  = MulW'(col_q);
        mul_b  = MulW'(w_eff) + MulW'(1);
      end
      default: ;
    endcase
  end

  tcgr_mul u_mul (
    .clk_i,
    .en_i   (mul_en),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  assign ram_we = accept && req_i.op
               && ({1'b0, req_i.char_code} < 9'(GLYPH_COUNT))
               && ({2'b00, req_i.glyph_line} < 7'(MAX_GLYPH_ROWS));
  assign ram_waddr = RamAw'(int'(req_i.char_code) * MAX_GLYPH_ROWS + int'(req_i.glyph_line));

  assign rd_line   = (state_q == S_EMIT) ? (y_q + GhW'(1)) : '0;
  assign ram_re    = (state_q == S_ADDCOL) || ((state_q == S_EMIT) && out_free && !last);
  assign ram_raddr = RamAw'(int'(code_q) * MAX_GLYPH_ROWS + int'(rd_line));

  tcgr_ram #(.Width(PixW), .Depth(Depth)) u_ram (
    .clk_i,
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (req_i.line_bits),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      row_q       <= '0;
      col_q       <= '0;
      code_q      <= '0;
      y_q         <= '0;
      acc_q       <= '0;
      rsp_valid_q <= 1'b0;
      rsp_addr_q  <= '0;
      rsp_mask_q  <= '0;
      rsp_color_q <= '0;
      rsp_last_q  <= 1'b0;
    end else begin
      if ((state_q == S_EMIT) && out_free) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept && !req_i.op && base_on) begin
            priority if (printable) begin
              code_q  <= req_i.char_code;
              state_q <= (h_eff == '0) ? S_ADV : S_MROW;
            end else if (req_i.char_code == ChBackspace) begin
              if (col_q != '0) begin
                col_q <= col_q - CurW'(1);
              end
            end else if (req_i.char_code == ChNewline) begin
              col_q <= '0;
              row_q <= row_wrap ? '0 : row_q + CurW'(1);
            end else begin
            end
          end
        end
        S_MROW: state_q <= S_MPITCH;
        S_MPITCH: begin
          acc_q   <= cfg.frame_base;
          state_q <= S_MCOL;
        end
        S_MCOL: begin
          acc_q   <= acc_q + AddrW'(prod);
          state_q <= S_ADDCOL;
        end
        S_ADDCOL: begin
          acc_q   <= acc_q + (AddrW'(prod) << 2);
          y_q     <= '0;
          state_q <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            rsp_addr_q  <= acc_q;
            rsp_mask_q  <= ram_rdata & keep;
            rsp_color_q <= cfg.text_color;
            rsp_last_q  <= last;
            acc_q       <= acc_q + AddrW'(cfg.line_pitch);
            y_q         <= y_q + GhW'(1);
            if (last) begin
              state_q <= S_ADV;
            end
          end
        end
        S_ADV: begin
          if (col_wrap) begin
            col_q <= '0;
            row_q <= row_wrap ? '0 : row_q + CurW'(1);
          end else begin
            col_q <= col_q + CurW'(1);
          end
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign req_i.ready         = (state_q == S_IDLE);
  assign rsp_o.valid         = rsp_valid_q;
  assign rsp_o.write_address = rsp_addr_q;
  assign rsp_o.pixel_mask    = rsp_mask_q;
  assign rsp_o.pixel_color   = rsp_color_q;
  assign rsp_o.last_row      = rsp_last_q;

`ifndef SYNTHESIS
  a_emit_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT) |-> (y_q < h_eff))
    else $error("glyph row index past glyph height");

  a_load_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == S_IDLE))
    else $error("glyph store written while drawing");

  a_emit_needs_base: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_q && !$past(rsp_valid_q)) |-> base_on)
    else $error("result produced with zero frame base");

  a_last_ends_draw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT && out_free && last) |=> (state_q == S_ADV && rsp_last_q))
    else $error("final glyph row not flagged");
`endif

endmodule

>>> verif/tb_text_console_glyph_renderer_core.sv
// Self-checking testbench for the text console glyph renderer: cursor, glyph store and row output.
module tb_text_console_glyph_renderer_core;
  import tcgr_pkg::*;

  localparam int MaxRows     = 32;
  localparam int MaxPixels   = 16;
  localparam int SettleTicks = 40;
  localparam int LongHold    = 400;
  localparam int CycleLimit  = 600000;

  typedef enum logic {
    OP_PRINT = 1'b0,
    OP_LOAD  = 1'b1
  } req_op_e;

  localparam logic [7:0] ChTab = 8'h09;

  typedef struct packed {
    logic [AddrW-1:0]  write_address;
    logic [PixW-1:0]   pixel_mask;
    logic [ColorW-1:0] pixel_color;
    logic              last_row;
  } glyph_row_t;

  class glyph_scoreboard;
    cfg_t            cfg;
    logic [CurW-1:0] cur_row;
    logic [CurW-1:0] cur_col;
    logic [PixW-1:0] glyph_rows [0:255][0:MaxRows-1];
    bit              loaded [0:255][0:MaxRows-1];
    glyph_row_t      pending_rows [$];
    int              errors;
    int              rows_checked;
    int              requests_seen;

    function new();
      cfg.frame_base   = FrameBaseRst;
      cfg.line_pitch   = LinePitchRst;
      cfg.glyph_width  = GlyphWidthRst;
      cfg.glyph_height = GlyphHeightRst;
      cfg.text_columns = TextColsRst;
      cfg.text_rows    = TextRowsRst;
      cfg.text_color   = TextColorRst;
      cur_row = '0;
      cur_col = '0;
      errors = 0;
      rows_checked = 0;
      requests_seen = 0;
    endfunction

    function void write_reg(reg_idx_e idx, logic [63:0] value);
      case (idx)
        REG_FRAME_BASE:   cfg.frame_base   = value[AddrW-1:0];
        REG_LINE_PITCH:   cfg.line_pitch   = value[PitchW-1:0];
        REG_GLYPH_WIDTH:  cfg.glyph_width  = value[GwW-1:0];
        REG_GLYPH_HEIGHT: cfg.glyph_height = value[GhW-1:0];
        REG_TEXT_COLUMNS: cfg.text_columns = value[CountW-1:0];
        REG_TEXT_ROWS:    cfg.text_rows    = value[CountW-1:0];
        REG_TEXT_COLOR:   cfg.text_color   = value[ColorW-1:0];
        default: ;
      endcase
    endfunction

    function int rows_per_glyph();
      return (cfg.glyph_height > MaxRows) ? MaxRows : int'(cfg.glyph_height);
    endfunction

    function int pixels_per_row();
      return (cfg.glyph_width > MaxPixels) ? MaxPixels : int'(cfg.glyph_width);
    endfunction

    function int pending();
      return pending_rows.size();
    endfunction

    function void next_line();
      int row_lim;
      row_lim = (cfg.text_rows > CursorLimit) ? int'(CursorLimit) : int'(cfg.text_rows);
      if (int'(cur_row) + 1 >= row_lim) cur_row = '0;
      else cur_row = cur_row + 1'b1;
      cur_col = '0;
    endfunction

    function void next_cell();
      int col_lim;
      col_lim = (cfg.text_columns > CursorLimit) ? int'(CursorLimit) : int'(cfg.text_columns);
      if (int'(cur_col) + 1 >= col_lim) next_line();
      else cur_col = cur_col + 1'b1;
    endfunction

    function void note_request(req_op_e op, logic [7:0] code, logic [4:0] line,
                               logic [15:0] bits);
      int          h;
      int          w;
      logic [15:0] keep;
      logic [63:0] base;
      glyph_row_t  row;
      requests_seen++;
      if (op == OP_LOAD) begin
        glyph_rows[code][line] = bits;
        loaded[code][line] = 1'b1;
        return;
      end
      if (cfg.frame_base == '0) return;
      if (code >= ChPrintLo && code < ChPrintEnd) begin
        h = rows_per_glyph();
        w = pixels_per_row();
        keep = (w == 0) ? 16'h0000 : (16'hFFFF << (MaxPixels - w));
        base = 64'(cfg.frame_base) + 64'(cur_row) * 64'(h + 1) * 64'(cfg.line_pitch)
             + 64'(cur_col) * 64'(w + 1) * 64'd4;
        for (int y = 0; y < h; y++) begin
          row.write_address = AddrW'(base + 64'(y) * 64'(cfg.line_pitch));
          row.pixel_mask    = glyph_rows[code][y] & keep;
          row.pixel_color   = cfg.text_color;
          row.last_row      = (y == h - 1);
          pending_rows.push_back(row);
        end
        next_cell();
      end else if (code == ChBackspace) begin
        if (cur_col != '0) cur_col = cur_col - 1'b1;
      end else if (code == ChNewline) begin
        next_line();
      end
    endfunction

    function void check_result(glyph_row_t got);
      glyph_row_t want;
      if (pending_rows.size() == 0) begin
        $error("glyph row with nothing expected: address %h", got.write_address);
        errors++;
        return;
      end
      want = pending_rows.pop_front();
      rows_checked++;
      if (got.write_address !== want.write_address) begin
        $error("write_address: expected %h, got %h", want.write_address, got.write_address);
        errors++;
      end
      if (got.pixel_mask !== want.pixel_mask) begin
        $error("pixel_mask: expected %h, got %h", want.pixel_mask, got.pixel_mask);
        errors++;
      end
      if (got.pixel_color !== want.pixel_color) begin
        $error("pixel_color: expected %h, got %h", want.pixel_color, got.pixel_color);
        errors++;
      end
      if (got.last_row !== want.last_row) begin
        $error("last_row: expected %b, got %b", want.last_row, got.last_row);
        errors++;
      end
    endfunction
  endclass

  logic              clk_i;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ApbAw-1:0]  paddr;
  logic [ApbDw-1:0]  pwdata;
  logic [ApbDw-1:0]  prdata;
  logic              pready;

  tcgr_req_if req_bus ();
  tcgr_rsp_if rsp_bus ();

  glyph_scoreboard sb = new();
  bit idle_on;
  int hold_token;
  int settings_run;

  logic [7:0] alphabet [0:4] = '{8'h20, 8'h41, 8'h57, 8'h61, 8'h7E};

  text_console_glyph_renderer_core u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_bus),
    .rsp_o   (rsp_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    repeat (CycleLimit) @(posedge clk_i);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // result side: random back-pressure, plus one long hold on request
  initial begin
    int gap_left;
    int hold_left;
    int tokens_seen;
    gap_left = 0;
    hold_left = 0;
    tokens_seen = 0;
    rsp_bus.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_token != tokens_seen) begin
        tokens_seen = hold_token;
        hold_left = LongHold;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_bus.ready <= 1'b0;
      end else if (gap_left > 0) begin
        gap_left--;
        rsp_bus.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        gap_left = $urandom_range(1, 11) - 1;
        rsp_bus.ready <= 1'b0;
      end else begin
        rsp_bus.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && rsp_bus.valid && rsp_bus.ready)
      sb.check_result('{rsp_bus.write_address, rsp_bus.pixel_mask, rsp_bus.pixel_color,
                        rsp_bus.last_row});
  end

  task automatic send_request(req_op_e op, logic [7:0] code, logic [4:0] line,
                              logic [15:0] bits);
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 11);
      req_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_bus.valid      <= 1'b1;
    req_bus.op         <= op;
    req_bus.char_code  <= code;
    req_bus.glyph_line <= line;
    req_bus.line_bits  <= bits;
    do @(posedge clk_i); while (!req_bus.ready);
    sb.note_request(op, code, line, bits);
  endtask

  // load any glyph rows still blank before the character is drawn
  task automatic print_char(logic [7:0] code);
    for (int y = 0; y < sb.rows_per_glyph(); y++)
      if (!sb.loaded[code][y]) send_request(OP_LOAD, code, 5'(y), 16'($urandom));
    send_request(OP_PRINT, code, 5'($urandom), 16'($urandom));
  endtask

  task automatic apb_write(reg_idx_e idx, logic [63:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    sb.write_reg(idx, value);
  endtask

  task automatic wait_idle();
    req_bus.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SettleTicks) @(posedge clk_i);
  endtask

  task automatic set_console(logic [47:0] base, logic [15:0] pitch, logic [4:0] gw,
                             logic [5:0] gh, logic [10:0] cols, logic [10:0] rows,
                             logic [31:0] color);
    wait_idle();
    apb_write(REG_FRAME_BASE, 64'(base));
    apb_write(REG_LINE_PITCH, 64'(pitch));
    apb_write(REG_GLYPH_WIDTH, 64'(gw));
    apb_write(REG_GLYPH_HEIGHT, 64'(gh));
    apb_write(REG_TEXT_COLUMNS, 64'(cols));
    apb_write(REG_TEXT_ROWS, 64'(rows));
    apb_write(REG_TEXT_COLOR, 64'(color));
    settings_run++;
  endtask

  task automatic random_request();
    logic [7:0] code;
    case ($urandom_range(0, 19))
      0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10: begin
        code = alphabet[$urandom_range(0, 4)];
        print_char(code);
      end
      11, 12: send_request(OP_PRINT, ChNewline, 5'($urandom), 16'($urandom));
      13, 14: send_request(OP_PRINT, ChBackspace, 5'($urandom), 16'($urandom));
      15: begin
        case ($urandom_range(0, 2))
          0: code = ChTab;
          1: code = 8'($urandom_range(0, 31));
          default: code = 8'($urandom_range(ChPrintEnd, 255));
        endcase
        if (code >= ChPrintLo && code < ChPrintEnd) print_char(code);
        else send_request(OP_PRINT, code, 5'($urandom), 16'($urandom));
      end
      16: begin
        code = 8'($urandom);
        if (code >= ChPrintLo && code < ChPrintEnd) print_char(code);
        else send_request(OP_PRINT, code, 5'($urandom), 16'($urandom));
      end
      default: send_request(OP_LOAD, 8'($urandom), 5'($urandom), 16'($urandom));
    endcase
  endtask

  task automatic run_random(int count, bit idling);
    idle_on = idling;
    repeat (count) random_request();
  endtask

  initial begin
    idle_on = 1'b1;
    hold_token = 0;
    settings_run = 0;
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    req_bus.valid = 1'b0;
    req_bus.op = OP_PRINT;
    req_bus.char_code = '0;
    req_bus.glyph_line = '0;
    req_bus.line_bits = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // base still zero: nothing drawn, cursor frozen
    send_request(OP_PRINT, 8'h41, 5'd0, 16'h0000);
    send_request(OP_PRINT, ChNewline, 5'd0, 16'h0000);
    send_request(OP_PRINT, ChBackspace, 5'd0, 16'h0000);

    // tiny screen near the top of the address space
    set_console(48'hFFFF_FFFF_F000, 16'hFFFF, 5'd16, 6'd2, 11'd3, 11'd2, 32'hFFFF_FFFF);
    send_request(OP_LOAD, ChPrintLo, 5'd0, 16'hFFFF);
    send_request(OP_LOAD, ChPrintLo, 5'd1, 16'h0000);
    send_request(OP_LOAD, 8'h7E, 5'd0, 16'h8001);
    send_request(OP_LOAD, 8'h7E, 5'd1, 16'hAAAA);
    send_request(OP_LOAD, 8'hFF, 5'd31, 16'h5555);
    send_request(OP_PRINT, ChPrintLo, 5'd0, 16'h0000);
    send_request(OP_PRINT, 8'h7E, 5'd0, 16'h0000);
    send_request(OP_PRINT, 8'h7E, 5'd0, 16'h0000);
    send_request(OP_PRINT, ChBackspace, 5'd0, 16'h0000);
    send_request(OP_PRINT, ChPrintLo, 5'd31, 16'hFFFF);
    send_request(OP_PRINT, ChBackspace, 5'd0, 16'h0000);
    send_request(OP_PRINT, ChNewline, 5'd0, 16'h0000);
    send_request(OP_PRINT, ChTab, 5'd0, 16'h0000);
    send_request(OP_PRINT, ChPrintEnd, 5'd0, 16'h0000);
    send_request(OP_PRINT, 8'hFF, 5'd0, 16'h0000);
    send_request(OP_PRINT, 8'h1F, 5'd0, 16'h0000);
    send_request(OP_PRINT, 8'h80, 5'd0, 16'h0000);

    set_console(48'h0000_1000_0000, 16'd5120, 5'd8, 6'd5, 11'd80, 11'd25, $urandom);
    run_random(10, 1'b1);
    set_console(48'h1, 16'h0000, 5'd0, 6'd1, 11'd0, 11'd0, 32'h0);
    run_random(8, 1'b1);

    // oversized glyph and screen settings, clamped to their limits
    set_console({16'($urandom), $urandom} | 48'h1, 16'($urandom), 5'd31, 6'd63, 11'd2047,
                11'd2047, $urandom);
    print_char(8'h7E);
    send_request(OP_PRINT, ChNewline, 5'd0, 16'h0000);
    print_char(8'h7E);
    send_request(OP_PRINT, ChBackspace, 5'd0, 16'h0000);

    set_console(48'h0, 16'd640, 5'd5, 6'd5, 11'd4, 11'd3, $urandom);
    run_random(6, 1'b1);
    set_console({16'($urandom), $urandom} | 48'h1, 16'($urandom), 5'd1, 6'd0, 11'd5, 11'd1,
                $urandom);
    run_random(8, 1'b1);

    // results held back for a long stretch while requests keep coming
    set_console(48'h0000_8000_0000, 16'd2048, 5'd16, 6'd32, 11'd7, 11'd3, $urandom);
    idle_on = 1'b0;
    hold_token++;
    repeat (10) print_char(8'h7E);

    set_console({16'($urandom), $urandom} | 48'h1, 16'($urandom), 5'($urandom_range(1, 16)),
                6'($urandom_range(1, 5)), 11'($urandom_range(1, 40)),
                11'($urandom_range(1, 30)), $urandom);
    run_random(12, 1'b0);

    wait_idle();
    $display("Run covered %0d requests and %0d glyph rows over %0d console settings",
             sb.requests_seen, sb.rows_checked, settings_run);
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
